// ===== hdl/sentinel_delimited_record_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// sentinel deframer assertion macros
// shared concurrent assertion forms, clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef SENTINEL_DELIMITED_RECORD_DEFRAMER_MACROS_SVH
`define SENTINEL_DELIMITED_RECORD_DEFRAMER_MACROS_SVH

// same-cycle implication
`define SDRD_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("sdrd assertion failed");

// next-cycle implication
`define SDRD_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("sdrd assertion failed");

`endif

// ===== hdl/sdrd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrd_pkg
// sentinel patterns, command format and matcher function for the deframer
// ----------------------------------------------------------------------------
package sdrd_pkg;

  localparam int START_PAT_BYTES = 9;
  localparam int STOP_PAT_BYTES  = 8;

  localparam logic [7:0] START_PAT [START_PAT_BYTES] =
    '{8'h23, 8'h23, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h23, 8'h23};
  localparam logic [7:0] STOP_PAT [STOP_PAT_BYTES] =
    '{8'h23, 8'h23, 8'h53, 8'h54, 8'h4f, 8'h50, 8'h23, 8'h23};

  // reset cap: 8000 samples/s for 3600 s
  localparam logic [31:0] CAP_RESET = 32'(8000 * 3600);

  // command queue between front and back end
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // operation codes double as the output kind codes
  typedef enum logic [1:0] {
    OP_AUDIO = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] cnt;     // bytes to release, 1..8
    logic       b_last;  // final released byte is the received byte
    logic [7:0] data;    // received byte
  } cmd_t;

  function automatic logic [7:0] pat_byte(input logic sel_stop, input int idx);
    logic [7:0] v;
    v = '0;
    if (sel_stop) begin
      if (idx >= 0 && idx < STOP_PAT_BYTES) v = STOP_PAT[idx[2:0]];
    end else begin
      if (idx >= 0 && idx < START_PAT_BYTES) v = START_PAT[idx[3:0]];
    end
    return v;
  endfunction

  // longest suffix of (pattern prefix of length p, then b) that is a prefix
  function automatic logic [3:0] match_advance(input logic sel_stop,
                                               input logic [3:0] p,
                                               input logic [7:0] b);
    logic       ok;
    logic [3:0] k_best;
    k_best = '0;
    for (int k = 1; k <= START_PAT_BYTES; k++) begin
      ok = (k <= int'(p) + 1) && (b == pat_byte(sel_stop, k - 1));
      for (int i = 0; i < START_PAT_BYTES - 1; i++) begin
        if (i < k - 1 &&
            pat_byte(sel_stop, int'(p) - k + 1 + i) != pat_byte(sel_stop, i))
          ok = 1'b0;
      end
      if (ok) k_best = 4'(k);
    end
    return k_best;
  endfunction

endpackage

// ===== hdl/sentinel_delimited_record_deframer.sv =====
// ----------------------------------------------------------------------------
// sentinel_delimited_record_deframer
// splits a received byte stream into records framed by ##START## / ##STOP##
// ----------------------------------------------------------------------------
// One received byte is accepted per cycle whenever the four-entry command
// queue has room; the sentinel matchers in the front end finish a byte in
// that same cycle. The back end handles each start marker, end marker and
// released audio byte in turn and feeds the output register, so the first
// result of a byte passes through the command queue and then the output
// register before it is offered on the output. A broken stop-sentinel
// prefix can release up to eight held bytes from one input byte; the back
// end drains them one per cycle while the output is not stalled, and the
// front keeps taking bytes until the queue fills. Bytes over the record
// cap are dropped with no result. There is no clearing pass after reset.
module sentinel_delimited_record_deframer import sdrd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // received byte requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result requests
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_audio_value,
  output logic [31:0] out_byte_total,
  output logic [15:0] out_record_number,
  output logic        out_capped,
  output logic        out_last,
  // cap register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_record_bytes
);

  logic push, pop, q_full, head_valid;
  cmd_t push_cmd, head_cmd;

  // cap register is always writable
  assign cfg_ready = 1'b1;

  // front end: sentinel tracking, command issue
  sdrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // decouples matching from release so bursts ride through
  sdrd_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (q_full)
  );

  // back end: record counters, cap, one result per cycle unless the output stalls
  sdrd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_max_record_bytes (cfg_max_record_bytes),
    .head_valid           (head_valid),
    .head_cmd             (head_cmd),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_audio_value      (out_audio_value),
    .out_byte_total       (out_byte_total),
    .out_record_number    (out_record_number),
    .out_capped           (out_capped),
    .out_last             (out_last)
  );

endmodule

// ===== hdl/sdrd_front.sv =====
// ----------------------------------------------------------------------------
// sdrd_front
// accepts received bytes, tracks sentinel matches, issues back-end commands
// ----------------------------------------------------------------------------
module sdrd_front import sdrd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  typedef enum logic {ST_HUNT, ST_RECORD} state_t;

  state_t     state_r, state_nxt;
  logic [3:0] sp_r, sp_nxt;
  logic [2:0] tp_r, tp_nxt;
  logic [3:0] k;
  logic [3:0] rel_cnt;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    tp_nxt        = tp_r;
    push          = 1'b0;
    push_cmd.op   = OP_AUDIO;
    push_cmd.cnt  = '0;
    push_cmd.b_last = 1'b0;
    push_cmd.data = in_rx_byte;
    k       = '0;
    rel_cnt = '0;
    unique case (state_r)
      ST_HUNT: begin
        k = match_advance(1'b0, sp_r, in_rx_byte);
        if (accept) begin
          if (k == 4'(START_PAT_BYTES)) begin
            state_nxt   = ST_RECORD;
            sp_nxt      = '0;
            tp_nxt      = '0;
            push        = 1'b1;
            push_cmd.op = OP_START;
          end else begin
            sp_nxt = k;
          end
        end
      end
      ST_RECORD: begin
        k       = match_advance(1'b1, {1'b0, tp_r}, in_rx_byte);
        rel_cnt = {1'b0, tp_r} + 4'd1 - k;
        if (accept) begin
          if (k == 4'(STOP_PAT_BYTES)) begin
            state_nxt   = ST_HUNT;
            sp_nxt      = '0;
            tp_nxt      = '0;
            push        = 1'b1;
            push_cmd.op = OP_STOP;
          end else begin
            tp_nxt = k[2:0];
            if (rel_cnt != '0) begin
              push            = 1'b1;
              push_cmd.op     = OP_AUDIO;
              push_cmd.cnt    = rel_cnt;
              push_cmd.b_last = (k == '0);
            end
          end
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      sp_r    <= '0;
      tp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      tp_r    <= tp_nxt;
    end
  end

endmodule

// ===== hdl/sdrd_cmdq.sv =====
// ----------------------------------------------------------------------------
// sdrd_cmdq
// small command queue between front and back end
// ----------------------------------------------------------------------------
module sdrd_cmdq import sdrd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd,
  output logic full
);

  cmd_t               slot_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_r, wr_nxt;
  logic [CMDQ_AW-1:0] rd_r, rd_nxt;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = slot_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_cmd;
  end

endmodule

// ===== hdl/sdrd_back.sv =====
// ----------------------------------------------------------------------------
// sdrd_back
// executes commands: markers, audio release with cap, output register
// ----------------------------------------------------------------------------
module sdrd_back import sdrd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_max_record_bytes,
  input  logic        head_valid,
  input  cmd_t        head_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_audio_value,
  output logic [31:0] out_byte_total,
  output logic [15:0] out_record_number,
  output logic        out_capped,
  output logic        out_last
);

  logic [31:0] max_r;
  logic [31:0] kept_r, kept_nxt;
  logic [15:0] rec_r, rec_nxt;
  logic        cap_r, cap_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  logic        load;
  logic [1:0]  ld_kind;
  logic [7:0]  ld_val;
  logic [31:0] ld_total;
  logic [15:0] ld_rec;
  logic        ld_cap, ld_last;
  logic        can_step, is_end;
  logic [3:0]  cnt_m1;
  logic [31:0] kept_inc;

  logic [1:0]  kind_r;
  logic [7:0]  val_r;
  logic [31:0] total_r;
  logic [15:0] rn_r;
  logic        capd_r, last_r;

  assign can_step = head_valid && (!ov_r || out_ready);
  assign cnt_m1   = head_cmd.cnt - 4'd1;
  assign is_end   = (idx_r == cnt_m1[2:0]);
  assign kept_inc = kept_r + 32'd1;

  always_comb begin
    kept_nxt = kept_r;
    rec_nxt  = rec_r;
    cap_nxt  = cap_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r && !out_ready;
    pop      = 1'b0;
    load     = 1'b0;
    ld_kind  = OP_AUDIO;
    ld_val   = '0;
    ld_total = '0;
    ld_rec   = rec_r;
    ld_cap   = 1'b0;
    ld_last  = 1'b1;
    if (can_step) begin
      case (head_cmd.op)
        OP_START: begin
          rec_nxt  = rec_r + 16'd1;
          kept_nxt = '0;
          cap_nxt  = 1'b0;
          load     = 1'b1;
          ld_kind  = OP_START;
          ld_rec   = rec_r + 16'd1;
          pop      = 1'b1;
        end
        OP_STOP: begin
          load     = 1'b1;
          ld_kind  = OP_STOP;
          ld_total = kept_r;
          ld_cap   = cap_r;
          pop      = 1'b1;
        end
        OP_AUDIO: begin
          if (kept_r < max_r) begin
            kept_nxt = kept_inc;
            load     = 1'b1;
            ld_kind  = OP_AUDIO;
            ld_val   = (head_cmd.b_last && is_end) ? head_cmd.data : STOP_PAT[idx_r];
            ld_total = kept_inc;
            ld_cap   = cap_r;
            // the next release would hit the cap and be dropped
            ld_last  = is_end || (kept_inc == max_r);
            if (is_end) begin
              pop     = 1'b1;
              idx_nxt = '0;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end else begin
            // cap hit: rest of this release is dropped at once
            cap_nxt = 1'b1;
            pop     = 1'b1;
            idx_nxt = '0;
          end
        end
        default: pop = 1'b1;
      endcase
    end
    if (load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= CAP_RESET;
      kept_r <= '0;
      rec_r  <= '0;
      cap_r  <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_max_record_bytes;
      kept_r <= kept_nxt;
      rec_r  <= rec_nxt;
      cap_r  <= cap_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= ld_kind;
      val_r   <= ld_val;
      total_r <= ld_total;
      rn_r    <= ld_rec;
      capd_r  <= ld_cap;
      last_r  <= ld_last;
    end
  end

  assign out_valid         = ov_r;
  assign out_kind          = kind_r;
  assign out_audio_value   = val_r;
  assign out_byte_total    = total_r;
  assign out_record_number = rn_r;
  assign out_capped        = capd_r;
  assign out_last          = last_r;

endmodule

// ===== hdl/sdrd_checker.sv =====
// ----------------------------------------------------------------------------
// sdrd_checker
// port-level assertions for the deframer, bound to the top level
// ----------------------------------------------------------------------------
`include "sentinel_delimited_record_deframer_macros.svh"

module sdrd_checker import sdrd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_audio_value,
  input logic [31:0] out_byte_total,
  input logic [15:0] out_record_number,
  input logic        out_capped,
  input logic        out_last
);

  // a stalled result holds
  `SDRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte_total) && $stable(out_kind) && $stable(out_audio_value))
  `SDRD_ASSERT_NOW(a_marker_no_audio, out_valid && out_kind != OP_AUDIO, out_audio_value == 8'd0)
  `SDRD_ASSERT_NOW(a_start_clean, out_valid && out_kind == OP_START, out_byte_total == 32'd0 && !out_capped && out_last)
  `SDRD_ASSERT_NOW(a_end_last, out_valid && out_kind == OP_STOP, out_last)
  `SDRD_ASSERT_NOW(a_audio_counted, out_valid && out_kind == OP_AUDIO, out_byte_total != 32'd0 && out_record_number != 16'd0)

endmodule

bind sentinel_delimited_record_deframer sdrd_checker u_sdrd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_audio_value   (out_audio_value),
  .out_byte_total    (out_byte_total),
  .out_record_number (out_record_number),
  .out_capped        (out_capped),
  .out_last          (out_last)
);
